/* hw/rtl/bcps_pkg.sv */
// ----------------------------------------------------------------------------
// bcps_pkg
// Shared types and constants for the byte class pattern search core.
// ----------------------------------------------------------------------------
package bcps_pkg;

	localparam int ALPHABET = 256;
	localparam int SYM_W    = 8;
	localparam int COL_W    = 32;
	localparam int CNT_W    = 32;
	localparam int PLEN_W   = 6;
	localparam int OFS_W    = 16;
	localparam int LEN_W    = 7;   // holds a clamped length up to 64
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE       = 2'd2;

	// per-byte control travelling down the pipeline
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [CNT_W-1:0] pos;
	} bcps_ctl_t;

endpackage

/* hw/rtl/bcps_cell.sv */
// ----------------------------------------------------------------------------
// bcps_cell
// One shift-and cell: holds one bit of the partial match vector.
// ----------------------------------------------------------------------------
module bcps_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  logic active,
	input  logic col_bit,
	input  logic chain_in,
	output logic match
);
	logic match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (shift_en) begin
			match_q <= chain_in & col_bit & active;
		end
	end

	assign match = match_q;

endmodule

/* hw/rtl/bcps_front.sv */
// ----------------------------------------------------------------------------
// bcps_front
// Input stage: class column memory, byte counter and first pipeline stage.
// ----------------------------------------------------------------------------
module bcps_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic                        cmd,
	input  logic [bcps_pkg::SYM_W-1:0]  column_symbol,
	input  logic [bcps_pkg::COL_W-1:0]  column_bits,
	input  logic [bcps_pkg::SYM_W-1:0]  data_byte,
	input  logic                        last,
	output bcps_pkg::bcps_ctl_t         ctl_s1,
	output logic [bcps_pkg::COL_W-1:0]  col_s1
);
	import bcps_pkg::*;

	logic [COL_W-1:0] col_mem [ALPHABET];
	logic [CNT_W-1:0] count_q;
	bcps_ctl_t        ctl_q_s1;
	logic [COL_W-1:0] col_q_s1;
	logic             accept;
	logic             take_data;

	assign accept    = in_valid & advance;
	assign take_data = accept & (cmd == CMD_DATA);

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_LOAD) begin
			col_mem[column_symbol] <= column_bits;
		end
		if (take_data) begin
			col_q_s1 <= col_mem[data_byte];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ctl_q_s1 <= '0;
		end else begin
			if (advance) begin
				ctl_q_s1.valid <= take_data;
			end
			if (take_data) begin
				ctl_q_s1.first <= (count_q == '0);
				ctl_q_s1.last  <= last;
				ctl_q_s1.pos   <= count_q;
				if (last) begin
					count_q <= '0;
				end else if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign ctl_s1 = ctl_q_s1;
	assign col_s1 = col_q_s1;

endmodule

/* hw/rtl/bcps_report.sv */
// ----------------------------------------------------------------------------
// bcps_report
// Match position tracking and the registered result stage.
// ----------------------------------------------------------------------------
module bcps_report (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcps_pkg::bcps_ctl_t         ctl_s1,
	input  logic                        full_hit,
	input  logic [bcps_pkg::LEN_W-1:0]  len_eff,
	input  logic [bcps_pkg::OFS_W-1:0]  start_offset,
	input  logic [bcps_pkg::CNT_W-1:0]  min_size,
	input  logic                        out_stall,
	output logic                        advance,
	output logic                        out_valid,
	output logic                        matches_at_start,
	output logic                        found,
	output logic [bcps_pkg::CNT_W-1:0]  next_offset
);
	import bcps_pkg::*;

	bcps_ctl_t        ctl_s2;
	logic             start_hit_q;
	logic             hit_valid_q;
	logic [CNT_W-1:0] hit_pos_q;
	logic             out_valid_q;
	logic             at_start_q;
	logic             found_q;
	logic [CNT_W-1:0] next_ofs_q;

	logic [CNT_W-1:0] lead;
	logic [CNT_W-1:0] need;
	logic [CNT_W-1:0] need_eff;
	logic [CNT_W-1:0] size;
	logic             hit;
	logic             hit_zero;
	logic             sh_nxt;
	logic             hv_nxt;
	logic [CNT_W-1:0] hp_nxt;
	logic             sh_base;
	logic             hv_base;
	logic             load;

	always_comb begin
		lead     = CNT_W'(start_offset) + CNT_W'(len_eff) - 1'b1;
		need     = CNT_W'(start_offset) + CNT_W'(len_eff);
		need_eff = (min_size > need) ? min_size : need;
		size     = (ctl_s2.pos == '1) ? ctl_s2.pos : ctl_s2.pos + 1'b1;
		hit      = full_hit & (ctl_s2.pos >= lead);
		hit_zero = (ctl_s2.pos == lead);
		// a stream's first byte starts from clean tracking state
		sh_base  = ctl_s2.first ? 1'b0 : start_hit_q;
		hv_base  = ctl_s2.first ? 1'b0 : hit_valid_q;
		sh_nxt   = sh_base | (hit & hit_zero);
		hv_nxt   = hv_base | (hit & ~hit_zero);
		hp_nxt   = hv_base ? hit_pos_q : ctl_s2.pos - lead;
	end

	assign advance = !(ctl_s2.valid && ctl_s2.last && out_valid_q && out_stall);
	assign load    = advance & ctl_s2.valid & ctl_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2      <= '0;
			start_hit_q <= 1'b0;
			hit_valid_q <= 1'b0;
			hit_pos_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				ctl_s2 <= ctl_s1;
				if (ctl_s2.valid) begin
					start_hit_q <= sh_nxt;
					hit_valid_q <= hv_nxt;
					hit_pos_q   <= hp_nxt;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (size < need_eff) begin
				at_start_q <= 1'b0;
				found_q    <= 1'b0;
				next_ofs_q <= size;
			end else begin
				at_start_q <= sh_nxt;
				found_q    <= hv_nxt;
				next_ofs_q <= hv_nxt ? hp_nxt : size;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign matches_at_start = at_start_q;
	assign found            = found_q;
	assign next_offset      = next_ofs_q;

endmodule

/* hw/rtl/byte_class_pattern_search_core.sv */
// ----------------------------------------------------------------------------
// byte_class_pattern_search_core
// Shift-and matcher for a pattern of byte classes at a fixed start offset.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): cmd=0 writes column_bits as the class
//    column of column_symbol; cmd=1 feeds data_byte, last closes the stream.
//  - While in_stall is low, one transaction is taken per cycle, loads and data
//    bytes alike; the rate is set by the single-port column memory read and the one-step cell row.
//  - A data byte with last=1 yields one result transaction on the output
//    channel (out_valid/out_stall) after the memory read at the edge that
//    accepts it, the cell row update and then the result register; a stalled
//    output can hold it in the report stage.
//  - Other transactions yield no result.
//  - While the result register is stalled, bytes that carry no result keep
//    flowing; only a second final byte reaching the report stage holds the
//    pipeline and raises in_stall.
//  - Configuration (cfg_valid/cfg_ready, always ready) is to be written between
//    streams, which the core does not enforce: index 0 pattern length, 1 start offset, 2 minimum size.
//  - Reset clears the match cells, byte counter, pipeline and result valid,
//    and sets the registers to length 1, offset 0, minimum size 0. The class
//    columns are not cleared; write every column before it is used.
// ----------------------------------------------------------------------------
module byte_class_pattern_search_core #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bcps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcps_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [bcps_pkg::SYM_W-1:0]     column_symbol,
	input  logic [bcps_pkg::COL_W-1:0]     column_bits,
	input  logic [bcps_pkg::SYM_W-1:0]     data_byte,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           matches_at_start,
	output logic                           found,
	output logic [bcps_pkg::CNT_W-1:0]     next_offset
);
	import bcps_pkg::*;

	logic [PLEN_W-1:0]      pattern_length_q;
	logic [OFS_W-1:0]       start_offset_q;
	logic [CNT_W-1:0]       min_size_q;
	logic [LEN_W-1:0]       plen_ext;
	logic [LEN_W-1:0]       len_eff;
	logic                   advance;
	bcps_ctl_t              ctl_s1;
	logic [COL_W-1:0]       col_s1;
	logic [MAX_PATTERN-1:0] vec;
	logic [MAX_PATTERN-1:0] end_sel;
	logic                   full_hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PLEN_W'(1);
			start_offset_q   <= '0;
			min_size_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[PLEN_W-1:0];
				REG_START_OFFSET:   start_offset_q   <= cfg_data[OFS_W-1:0];
				REG_MIN_SIZE:       min_size_q       <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		plen_ext = LEN_W'(pattern_length_q);
		if (plen_ext == '0) begin
			len_eff = LEN_W'(1);
		end else if (plen_ext > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = plen_ext;
		end
	end

	assign in_stall = ~advance;

	bcps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.in_valid      (in_valid),
		.cmd           (cmd),
		.column_symbol (column_symbol),
		.column_bits   (column_bits),
		.data_byte     (data_byte),
		.last          (last),
		.ctl_s1        (ctl_s1),
		.col_s1        (col_s1)
	);

	// cell k holds "positions 0..k match ending at the latest byte"
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic col_bit;
		logic chain_in;

		if (k < COL_W) begin : g_col
			assign col_bit = col_s1[k];
		end else begin : g_nocol
			assign col_bit = 1'b0;
		end

		if (k == 0) begin : g_head
			assign chain_in = 1'b1;
		end else begin : g_link
			assign chain_in = ~ctl_s1.first & vec[k-1];
		end

		assign end_sel[k] = (len_eff == LEN_W'(k + 1));

		bcps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (advance & ctl_s1.valid),
			.active   (len_eff > LEN_W'(k)),
			.col_bit  (col_bit),
			.chain_in (chain_in),
			.match    (vec[k])
		);
	end

	assign full_hit = |(vec & end_sel);

	bcps_report u_report (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl_s1           (ctl_s1),
		.full_hit         (full_hit),
		.len_eff          (len_eff),
		.start_offset     (start_offset_q),
		.min_size         (min_size_q),
		.out_stall        (out_stall),
		.advance          (advance),
		.out_valid        (out_valid),
		.matches_at_start (matches_at_start),
		.found            (found),
		.next_offset      (next_offset)
	);

endmodule

/* hw/rtl/bcps_checker.sv */
// ----------------------------------------------------------------------------
// bcps_checker
// Port-level checks for the byte class pattern search core.
// ----------------------------------------------------------------------------
module bcps_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       cmd,
	input logic                       last,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       matches_at_start,
	input logic                       found,
	input logic [bcps_pkg::CNT_W-1:0] next_offset
);
	import bcps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(next_offset) && $stable(found)
			&& $stable(matches_at_start))
		else $error("result payload changed while stalled");

	// a fresh result comes from an accepted final data byte
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && cmd == CMD_DATA && last, 3))
		else $error("result without a matching final byte");

	// a later match lies at position one or beyond
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> next_offset != '0)
		else $error("found reported at position zero");

endmodule

bind byte_class_pattern_search_core bcps_checker u_bcps_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.cmd              (cmd),
	.last             (last),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.matches_at_start (matches_at_start),
	.found            (found),
	.next_offset      (next_offset)
);

/* tb/byte_class_pattern_search_core_tb.sv */
// ----------------------------------------------------------------------------
// byte_class_pattern_search_core_tb
// Self-checking bench for the byte class pattern search core. A driver feeds
// column loads and data streams from a queue, and a monitor predicts the
// per-stream report with a bit-accurate shift-and matcher of its own. The
// monitor then checks every result transaction field by field. Register
// settings change between phases, and both channels idle in random bursts.
// One phase holds the output off for a long stretch so that the core fills up.
// ----------------------------------------------------------------------------
module byte_class_pattern_search_core_tb;
	import bcps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int MAXP          = 32;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RAND_ITEMS    = 400;
	localparam int RAND_STREAMS  = 24;

	typedef struct {
		logic             cmd;
		logic [SYM_W-1:0] symbol;
		logic [COL_W-1:0] bits;
		logic [SYM_W-1:0] dbyte;
		logic             last;
	} feed_item_t;

	typedef struct {
		logic             at_start;
		logic             found;
		logic [CNT_W-1:0] next_ofs;
	} search_report_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_DAT_W-1:0] cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic                 cmd           = CMD_LOAD;
	logic [SYM_W-1:0]     column_symbol = '0;
	logic [COL_W-1:0]     column_bits   = '0;
	logic [SYM_W-1:0]     data_byte     = '0;
	logic                 last          = 1'b0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic                 matches_at_start;
	logic                 found;
	logic [CNT_W-1:0]     next_offset;

	byte_class_pattern_search_core u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// matcher copy: registers, class table and per-stream state
	logic [PLEN_W-1:0] cur_len = PLEN_W'(1);
	logic [OFS_W-1:0]  cur_ofs = '0;
	logic [CNT_W-1:0]  cur_min = '0;
	logic [COL_W-1:0]  class_tbl [ALPHABET];
	logic [63:0]       match_bits    = '0;
	logic [CNT_W-1:0]  seen_bytes    = '0;
	logic              hit_at_zero   = 1'b0;
	logic              hit_later     = 1'b0;
	logic [CNT_W-1:0]  hit_later_pos = '0;
	search_report_t    report_q[$];

	feed_item_t feed_q[$];
	feed_item_t drv_item, mon_item;
	search_report_t mon_rep;

	int  err_cnt = 0;
	int  n_loads = 0, n_bytes = 0, n_reports = 0, n_cfg = 0, n_settings = 0;
	int  stall_run = 0, max_stall_run = 0;
	int  quiet_cycles = 0;
	int  src_gap = 0, snk_gap = 0, hold_left = 0;
	bit  src_idle = 1'b1, snk_idle = 1'b1;

	// stimulus side bookkeeping
	bit               written [ALPHABET];
	logic [SYM_W-1:0] written_list[$];
	logic [SYM_W-1:0] alpha[$];
	logic [7:0]       cls [MAXP];
	int unsigned      g_len = 1, g_ofs = 0;
	int               gen_items = 0, gen_streams = 0;

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		err_cnt++;
		$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	task automatic advance_matcher(input feed_item_t it);
		int unsigned    n;
		logic [63:0]    len_mask, lead, need, size, p;
		search_report_t r;
		if (it.cmd == CMD_LOAD) begin
			class_tbl[it.symbol] = it.bits;
			return;
		end
		n = 32'(cur_len);
		if (n < 1) n = 1;
		if (n > MAXP) n = MAXP;
		len_mask   = (64'd1 << n) - 64'd1;
		match_bits = ((match_bits << 1) | 64'd1) & {32'd0, class_tbl[it.dbyte]} & len_mask;
		lead       = 64'(cur_ofs) + 64'(n) - 64'd1;
		// a full match ending here belongs to the candidate lead bytes back
		if (match_bits[n-1] && 64'(seen_bytes) >= lead) begin
			p = 64'(seen_bytes) - lead;
			if (p == 64'd0) begin
				hit_at_zero = 1'b1;
			end else if (!hit_later) begin
				hit_later     = 1'b1;
				hit_later_pos = p[CNT_W-1:0];
			end
		end
		if (seen_bytes != '1) seen_bytes++;
		if (!it.last) return;
		size = 64'(seen_bytes);
		need = 64'(cur_ofs) + 64'(n);
		if (64'(cur_min) > need) need = 64'(cur_min);
		if (size < need) begin
			r.at_start = 1'b0;
			r.found    = 1'b0;
			r.next_ofs = seen_bytes;
		end else begin
			r.at_start = hit_at_zero;
			r.found    = hit_later;
			r.next_ofs = hit_later ? hit_later_pos : seen_bytes;
		end
		report_q.insert(report_q.size(), r);
		match_bits    = '0;
		seen_bytes    = '0;
		hit_at_zero   = 1'b0;
		hit_later     = 1'b0;
		hit_later_pos = '0;
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (src_gap != 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (src_idle && $urandom_range(0, 7) == 0) begin
				src_gap = $urandom_range(0, 15);
				in_valid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				drv_item = feed_q.pop_front();
				cmd           <= drv_item.cmd;
				column_symbol <= drv_item.symbol;
				column_bits   <= drv_item.bits;
				data_byte     <= drv_item.dbyte;
				last          <= drv_item.last;
				in_valid      <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: long hold-off first, then random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (snk_gap != 0) begin
			snk_gap--;
			out_stall <= 1'b1;
		end else if (snk_idle && $urandom_range(0, 7) == 0) begin
			snk_gap = $urandom_range(0, 15);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: register writes, input transactions, result checks
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				n_cfg++;
				case (cfg_index)
					REG_PATTERN_LENGTH: cur_len = cfg_data[PLEN_W-1:0];
					REG_START_OFFSET:   cur_ofs = cfg_data[OFS_W-1:0];
					REG_MIN_SIZE:       cur_min = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				mon_item.cmd    = cmd;
				mon_item.symbol = column_symbol;
				mon_item.bits   = column_bits;
				mon_item.dbyte  = data_byte;
				mon_item.last   = last;
				if (cmd == CMD_LOAD) n_loads++;
				else n_bytes++;
				advance_matcher(mon_item);
			end
			if (in_valid && in_stall) stall_run++;
			else stall_run = 0;
			if (stall_run > max_stall_run) max_stall_run = stall_run;
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					note_mismatch("unexpected result, next_offset", '0, next_offset);
				end else begin
					mon_rep = report_q.pop_front();
					n_reports++;
					if (matches_at_start !== mon_rep.at_start)
						note_mismatch("matches_at_start", 32'(mon_rep.at_start),
							32'(matches_at_start));
					if (found !== mon_rep.found)
						note_mismatch("found", 32'(mon_rep.found), 32'(found));
					if (next_offset !== mon_rep.next_ofs)
						note_mismatch("next_offset", mon_rep.next_ofs, next_offset);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
				QUIET_LIMIT, report_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic queue_load(input logic [SYM_W-1:0] sym, input logic [COL_W-1:0] bits);
		feed_item_t it;
		it.cmd    = CMD_LOAD;
		it.symbol = sym;
		it.bits   = bits;
		it.dbyte  = SYM_W'($urandom());
		it.last   = 1'($urandom_range(0, 1));
		feed_q.insert(feed_q.size(), it);
		gen_items++;
		if (!written[sym]) begin
			written[sym] = 1'b1;
			written_list.insert(written_list.size(), sym);
		end
	endtask

	task automatic queue_byte(input logic [SYM_W-1:0] b, input logic lst);
		feed_item_t it;
		it.cmd    = CMD_DATA;
		it.symbol = SYM_W'($urandom());
		it.bits   = $urandom();
		it.dbyte  = b;
		it.last   = lst;
		feed_q.insert(feed_q.size(), it);
		gen_items++;
		if (lst) gen_streams++;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (feed_q.size() != 0 || in_valid || report_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// upper bits of the narrow registers carry noise
	task automatic program_search(input int unsigned len_raw, input int unsigned ofs,
			input logic [31:0] min_sz);
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, ($urandom() & ~32'h3F) | len_raw);
		write_reg(REG_START_OFFSET, ($urandom() & ~32'hFFFF) | ofs);
		write_reg(REG_MIN_SIZE, min_sz);
		if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
		g_len = (len_raw == 0) ? 1 : (len_raw > MAXP) ? MAXP : len_raw;
		g_ofs = ofs;
		n_settings++;
		@(negedge clk);
	endtask

	// small alphabet with random classes per pattern position
	task automatic new_alphabet();
		int unsigned      asz, j, k;
		logic [SYM_W-1:0] s;
		logic [COL_W-1:0] col;
		bit               dup;
		asz = $urandom_range(2, 6);
		alpha.delete();
		while (alpha.size() < asz) begin
			s   = SYM_W'($urandom());
			dup = 1'b0;
			foreach (alpha[i]) if (alpha[i] == s) dup = 1'b1;
			if (!dup) alpha.insert(alpha.size(), s);
		end
		for (k = 0; k < MAXP; k++) cls[k] = 8'($urandom_range(1, (1 << asz) - 1));
		for (j = 0; j < asz; j++) begin
			for (k = 0; k < MAXP; k++) col[k] = cls[k][j];
			queue_load(alpha[j], col);
		end
		repeat ($urandom_range(0, 3)) queue_load(SYM_W'($urandom()), $urandom());
	endtask

	function automatic logic [SYM_W-1:0] class_member(input int unsigned k);
		int unsigned j;
		do j = $urandom_range(0, alpha.size() - 1); while (!cls[k][j]);
		return alpha[j];
	endfunction

	// mostly well-formed: planted full or partial matches, some noise bytes,
	// an occasional column rewrite mid-stream and some short streams
	task automatic queue_random_stream();
		logic [SYM_W-1:0] bytes[$];
		int unsigned      total, need, at, upto, i, k;
		need  = g_ofs + g_len;
		total = need + $urandom_range(0, 10);
		if ($urandom_range(0, 5) == 0) total = $urandom_range(1, need);
		for (i = 0; i < total; i++)
			bytes.insert(bytes.size(), alpha[$urandom_range(0, alpha.size() - 1)]);
		if ($urandom_range(0, 9) < 7) begin
			upto = g_len;
			if ($urandom_range(0, 3) == 0) upto = $urandom_range(1, g_len);
			at = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, total);
			for (k = 0; k < upto; k++)
				if (at + g_ofs + k < total) bytes[at + g_ofs + k] = class_member(k);
		end
		for (i = 0; i < total; i++) begin
			if ($urandom_range(0, 24) == 0)
				bytes[i] = written_list[$urandom_range(0, written_list.size() - 1)];
			if ($urandom_range(0, 40) == 0)
				queue_load(alpha[$urandom_range(0, alpha.size() - 1)], $urandom());
			queue_byte(bytes[i], i == total - 1);
		end
	endtask

	initial begin
		int          ph;
		int unsigned len_raw, ofs;
		logic [31:0] min_sz;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset register values first
		queue_load(8'h00, 32'hFFFF_FFFF);
		queue_load(8'hFF, 32'h0000_0000);
		queue_load(8'h5A, 32'h0000_0001);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b1);
		// zero length reads as one; short stream, then an exact-size stream
		program_search(0, 2, 32'd5);
		repeat (2) queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		repeat (4) queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		// largest offset and minimum size
		program_search(2, 16'hFFFF, 32'hFFFF_FFFF);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		// column rewrite inside a stream applies from the next byte
		program_search(2, 0, 32'd0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		queue_byte(8'h5A, 1'b0);
		queue_load(8'h5A, 32'h0000_0003);
		queue_byte(8'h5A, 1'b1);

		// random phases
		gen_items   = 0;
		gen_streams = 0;
		ph = 0;
		while (gen_items < RAND_ITEMS || gen_streams < RAND_STREAMS) begin
			ofs    = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
			min_sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : 0;
			len_raw = ($urandom_range(0, 5) == 0) ? MAXP : $urandom_range(1, 8);
			case (ph)
				0: len_raw = MAXP;
				1: len_raw = 0;
				2: len_raw = $urandom_range(MAXP + 1, 63);
				3: min_sz  = 32'hFFFF_FFFF;
				default: ;
			endcase
			program_search(len_raw, ofs, min_sz);
			src_idle = $urandom_range(0, 3) != 0;
			snk_idle = $urandom_range(0, 3) != 0;
			new_alphabet();
			repeat (6) queue_random_stream();
			ph++;
		end

		// receiver holds off while the sender keeps offering short streams
		program_search($urandom_range(1, 3), $urandom_range(0, 1), 32'd0);
		src_idle = 1'b0;
		snk_idle = 1'b1;
		new_alphabet();
		hold_left = HOLD_CYCLES;
		repeat (40) begin
			if ($urandom_range(0, 1) == 0) queue_byte(alpha[0], 1'b1);
			else queue_random_stream();
		end

		// last part without idling
		program_search($urandom_range(1, MAXP), $urandom_range(0, 4), $urandom_range(0, 20));
		src_idle = 1'b0;
		snk_idle = 1'b0;
		new_alphabet();
		repeat (8) queue_random_stream();

		wait_idle();
		repeat (20) @(negedge clk);
		$display("covered %0d column loads, %0d data bytes, %0d stream reports",
			n_loads, n_bytes, n_reports);
		$display("over %0d register settings (%0d writes); longest input stall %0d cycles",
			n_settings, n_cfg, max_stall_run);
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
